### rtl/core/cst_pkg.sv
// Shared types, codes and constants for the coordinate set table.
package cst_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int COORD_MAX        = 31;

   localparam int OPCODE_W   = 2;
   localparam int COORD_W    = 5;
   localparam int INDEX_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;
   localparam int KEY_W      = 2 * COORD_W;

   // Largest coordinate value a field can carry after saturation.
   localparam logic [COORD_W-1:0] COORD_LIMIT =
      (COORD_MAX > 31) ? 5'd31 : COORD_W'(COORD_MAX);

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // Read address selection for the table memory.
   localparam logic [1:0] RD_SEL_INDEX    = 2'd0;
   localparam logic [1:0] RD_SEL_PTR      = 2'd1;
   localparam logic [1:0] RD_SEL_PTR_NEXT = 2'd2;
   localparam logic [1:0] RD_SEL_LAST     = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  column;
      logic [INDEX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  found;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    count;
      logic [COORD_W-1:0]    row_out;
      logic [COORD_W-1:0]    column_out;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic                accept;
      logic [1:0]          rd_sel;
      logic                ptr_inc;
      logic                hit_set;
      logic                append;
      logic                move;
      logic                read_ok;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                idx_ok;
      logic                count_zero;
      logic                full;
      logic                match;
      logic                last;
      logic                hit;
      logic                rsp_free;
   } stat_type;

endpackage

### rtl/core/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cst_datapath.sv
// Datapath: request latch, scan pointer, entry count, table memory, result register.
module cst_datapath #(
   parameter int CAPACITY = cst_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cst_pkg::req_type  req_data,
   input  cst_pkg::cmd_type  cmd,
   output cst_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cst_pkg::rsp_type  rsp_data
);
   import cst_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [OPCODE_W-1:0] op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [AW-1:0]       ptr_ff,    ptr_in;
   logic [AW-1:0]       pos_ff,    pos_in;
   logic                hit_ff,    hit_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COORD_W-1:0]  rout_ff,   rout_in;
   logic [COORD_W-1:0]  cout_ff,   cout_in;
   logic [CW-1:0]       count_ff,  count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff,       rsp_in;

   logic [COORD_W-1:0]  row_sat, col_sat;
   logic [XW-1:0]       idx_ext, count_ext, ptr_ext, pos_ext, last_ext;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [KEY_W-1:0]    rd_data, wr_data;
   logic                wr_en;

   assign row_sat = (req_data.row    > COORD_LIMIT) ? COORD_LIMIT : req_data.row;
   assign col_sat = (req_data.column > COORD_LIMIT) ? COORD_LIMIT : req_data.column;

   assign idx_ext   = XW'(idx_ff);
   assign count_ext = XW'(count_ff);
   assign ptr_ext   = XW'(ptr_ff);
   assign pos_ext   = XW'(pos_ff);
   assign last_ext  = count_ext - XW'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_SEL_INDEX:    rd_addr = idx_ext[AW-1:0];
         RD_SEL_PTR:      rd_addr = ptr_ff;
         RD_SEL_PTR_NEXT: rd_addr = ptr_ff + AW'(1);
         RD_SEL_LAST:     rd_addr = last_ext[AW-1:0];
         default:         rd_addr = ptr_ff;
      endcase
   end

   // Remove copies the last entry over the hit; insert appends at the count.
   assign wr_en   = cmd.append | cmd.move;
   assign wr_addr = cmd.move ? pos_ff : count_ext[AW-1:0];
   assign wr_data = cmd.move ? rd_data : key_ff;

   cst_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      status_in = status_ff;
      rout_in   = rout_ff;
      cout_in   = cout_ff;
      count_in  = count_ff;
      if (cmd.accept) begin
         ptr_in    = '0;
         pos_in    = '0;
         hit_in    = 1'b0;
         status_in = ST_OK;
         rout_in   = '0;
         cout_in   = '0;
      end
      if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + AW'(1);
      end
      if (cmd.hit_set) begin
         hit_in = 1'b1;
         pos_in = ptr_ff;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.read_ok) begin
         rout_in = rd_data[KEY_W-1:COORD_W];
         cout_in = rd_data[COORD_W-1:0];
      end
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.move) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in.status     = status_ff;
      rsp_in.found      = hit_ff;
      rsp_in.position   = pos_ext[POSITION_W-1:0];
      rsp_in.count      = count_ext[COUNT_W-1:0];
      rsp_in.row_out    = rout_ff;
      rsp_in.column_out = cout_ff;
      rsp_valid_in      = cmd.rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_data.opcode;
         key_ff <= {row_sat, col_sat};
         idx_ff <= req_data.index;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      rout_ff   <= rout_in;
      cout_ff   <= cout_in;
   end

   always_comb begin
      stat.op         = op_ff;
      stat.idx_ok     = idx_ext < count_ext;
      stat.count_zero = count_ff == '0;
      stat.full       = count_ff == CW'(CAPACITY);
      stat.match      = rd_data == key_ff;
      stat.last       = (ptr_ext + XW'(1)) == count_ext;
      stat.hit        = hit_ff;
      stat.rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/cst_controller.sv
// Controller: sequences dispatch, table scan, update and result hand-off.
module cst_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cst_pkg::stat_type stat,
   output cst_pkg::cmd_type  cmd
);
   import cst_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_START     = 3'd1;
   localparam logic [2:0] S_SCAN      = 3'd2;
   localparam logic [2:0] S_POST      = 3'd3;
   localparam logic [2:0] S_MOVE      = 3'd4;
   localparam logic [2:0] S_READ_WAIT = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (stat.op == OP_READ) begin
               if (stat.idx_ok) begin
                  cmd.rd_sel = RD_SEL_INDEX;
                  state_in   = S_READ_WAIT;
               end else begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_RANGE;
                  state_in        = S_DONE;
               end
            end else if (stat.count_zero) begin
               state_in = S_POST;
            end else begin
               cmd.rd_sel = RD_SEL_PTR;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // Compare one entry per cycle while the next read is in flight.
            if (stat.match) begin
               cmd.hit_set = 1'b1;
               state_in    = S_POST;
            end else if (stat.last) begin
               state_in = S_POST;
            end else begin
               cmd.ptr_inc = 1'b1;
               cmd.rd_sel  = RD_SEL_PTR_NEXT;
            end
         end
         S_POST: begin
            state_in = S_DONE;
            case (stat.op)
               OP_INSERT: begin
                  if (!stat.hit) begin
                     if (stat.full) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_FULL;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (stat.hit) begin
                     cmd.rd_sel = RD_SEL_LAST;
                     state_in   = S_MOVE;
                  end else begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_ABSENT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_DONE;
         end
         S_READ_WAIT: begin
            cmd.read_ok = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/coordinate_set_table.sv
// Top level of the coordinate set table.
//
// Keeps a set of distinct (row, column) pairs in a packed table of CAPACITY
// entries plus a count, and answers insert, remove, lookup and read-at-index
// requests with one response transaction each. Coordinates above COORD_MAX
// saturate before use. Entries live in a single-port-read RAM, so a lookup,
// insert or remove walks the table one entry per cycle, stopping at the
// first hit or the last entry; a successful remove then copies the last
// entry into the hole. A lookup, insert or remove passes through the start,
// scan (skipped on an empty table), post and, for a removal hit, move states;
// a read passes through the start and, when in range, read-wait states; each
// then waits in the done state for the response register. One request is
// in work at a time; the next is accepted once the previous result sits in
// the response register, which holds it under rsp_stall while the next
// request proceeds. No clearing pass is needed after reset: only positions
// below the count are ever read, and those were always written first.
module coordinate_set_table #(
   parameter int CAPACITY = cst_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence each transaction: dispatch, scan, update, hand off.
   cst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the table, count, scan pointer and response register.
   cst_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/cst_checker.sv
// Port-level checker for the coordinate set table, bound to the top level.
module cst_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cst_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid & ~req_stall;
   assign rsp_take = rsp_valid & ~rsp_stall;
   assign pend_in  = pend_ff + {1'b0, req_take} - {1'b0, rsp_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Never more than one transaction in work plus one waiting response.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two transactions outstanding");

   // A response never appears without an accepted request behind it.
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without request (req opcode %0d)", req_data.opcode);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // An error status never comes with a hit.
   a_error_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         !rsp_data.found && rsp_data.position == '0)
      else $error("error status reported with a hit");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_RANGE |->
         rsp_data.row_out == '0 && rsp_data.column_out == '0)
      else $error("out-of-range read returned data");

endmodule

bind coordinate_set_table cst_checker u_checker (.*);

### tb/coordinate_set_table_tb.sv
// Self-checking testbench for the coordinate set table.
module coordinate_set_table_tb;
   import cst_pkg::*;

   localparam int CAP           = CAPACITY_DEFAULT;
   localparam int SLOT_W        = $clog2(CAP);
   localparam int RANDOM_ITEMS  = 1230;
   localparam int PRESSURE_HOLD = 300;
   // Worst walk plus remove copy plus response register, with margin.
   localparam int DRAIN_CYCLES  = CAP + 40;
   localparam int SETTLE_LIMIT  = 200000;

   // Scoreboard: mirror of the table, queue of predicted response transactions.
   class coord_set_scoreboard;
      logic [KEY_W-1:0] slots [CAP];
      int               stored_count;
      rsp_type          pending_answers [$];
      int               errors;

      function new();
         stored_count = 0;
         errors       = 0;
      endfunction

      // Apply one accepted request to the mirror and queue its answer.
      function void apply_request(req_type r);
         logic [COORD_W-1:0] row_c;
         logic [COORD_W-1:0] col_c;
         logic [KEY_W-1:0]   key;
         rsp_type            x;
         int                 hit_at;
         int                 i;
         row_c = (r.row > COORD_LIMIT) ? COORD_LIMIT : r.row;
         col_c = (r.column > COORD_LIMIT) ? COORD_LIMIT : r.column;
         key   = {row_c, col_c};
         x     = '0;
         if (r.opcode == OP_READ) begin
            if (int'(r.index) < stored_count) begin
               x.row_out    = slots[r.index][KEY_W-1:COORD_W];
               x.column_out = slots[r.index][COORD_W-1:0];
            end else begin
               x.status = ST_RANGE;
            end
         end else begin
            hit_at = -1;
            for (i = 0; i < stored_count; i++) begin
               if (hit_at < 0 && slots[SLOT_W'(i)] == key) hit_at = i;
            end
            if (hit_at >= 0) begin
               x.found    = 1'b1;
               x.position = POSITION_W'(hit_at);
            end
            case (r.opcode)
               OP_INSERT: begin
                  if (hit_at < 0) begin
                     if (stored_count < CAP) begin
                        slots[SLOT_W'(stored_count)] = key;
                        stored_count++;
                     end else begin
                        x.status = ST_FULL;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (hit_at >= 0) begin
                     slots[SLOT_W'(hit_at)] = slots[SLOT_W'(stored_count-1)];
                     stored_count--;
                  end else begin
                     x.status = ST_ABSENT;
                  end
               end
               default: ;
            endcase
         end
         x.count = COUNT_W'(stored_count);
         pending_answers.insert(pending_answers.size(), x);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // Check one accepted response transaction against the oldest answer.
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         compare_field("status",     int'(want.status),     int'(got.status));
         compare_field("found",      int'(want.found),      int'(got.found));
         compare_field("position",   int'(want.position),   int'(got.position));
         compare_field("count",      int'(want.count),      int'(got.count));
         compare_field("row_out",    int'(want.row_out),    int'(got.row_out));
         compare_field("column_out", int'(want.column_out), int'(got.column_out));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   coord_set_scoreboard sb = new();

   // Idle rates in percent; the stimulus process moves them between phases.
   int send_idle_pct = 28;
   int recv_idle_pct = 49;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit pressure_pending = 1'b0;

   coordinate_set_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10000000;
      $display("Regression FAIL");
      $finish;
   end

   // Drive one request transaction. Enter and leave at a falling edge, so
   // valid gets at most one assignment per falling edge; it stays high from
   // one transaction straight into the next when no idle cycle is drawn.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
         // Hold the payload while the block stalls.
         @(negedge clock);
      end
      sb.apply_request(r);
      @(negedge clock);
   endtask

   function automatic req_type make_request(input logic [OPCODE_W-1:0] op,
                                            input int row, input int column,
                                            input int index);
      req_type r;
      r.opcode = op;
      r.row    = COORD_W'(row);
      r.column = COORD_W'(column);
      r.index  = INDEX_W'(index);
      return r;
   endfunction

   // Draw a random request. While growing, inserts dominate so the table
   // fills up and hits the full case; while shrinking, removes dominate so
   // it drains back to empty. Coordinates are often taken from the table
   // so hits, duplicate inserts and swap-with-last removes happen a lot.
   function automatic req_type random_request(input bit growing);
      req_type r;
      int      roll;
      int      reuse_pct;
      int      n;
      n        = sb.stored_count;
      r.row    = COORD_W'($urandom_range(31));
      r.column = COORD_W'($urandom_range(31));
      r.index  = INDEX_W'($urandom_range(63));
      roll     = $urandom_range(99);
      if (growing) begin
         r.opcode = (roll < 60) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                    (roll < 85) ? OP_LOOKUP : OP_READ;
      end else begin
         r.opcode = (roll < 15) ? OP_INSERT : (roll < 65) ? OP_REMOVE :
                    (roll < 82) ? OP_LOOKUP : OP_READ;
      end
      reuse_pct = (r.opcode == OP_INSERT) ? 40 : 75;
      if (n > 0 && $urandom_range(99) < reuse_pct)
         {r.row, r.column} = sb.slots[SLOT_W'($urandom_range(n-1))];
      // Mostly read valid positions; the rest probes out-of-range indexes.
      if (r.opcode == OP_READ && n > 0 && $urandom_range(99) < 70)
         r.index = INDEX_W'($urandom_range(n-1));
      return r;
   endfunction

   // Receiver: draw stall at each falling edge; serve a long hold-off when
   // asked, counting its cycles here so the sender keeps offering meanwhile.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (pressure_pending) begin
            pressure_pending = 1'b0;
            hold_left        = PRESSURE_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Sample response transactions at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // Stimulus.
   initial begin
      bit growing;
      int full_tries;
      int k;
      int waited;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty table, corner coordinates, duplicates, absent
      // removes, swap-with-last on remove, range errors on read.
      send_request(make_request(OP_READ,   0,  0,  0));  // read on empty table
      send_request(make_request(OP_LOOKUP, 5,  7,  0));  // lookup on empty table
      send_request(make_request(OP_REMOVE, 5,  7,  0));  // remove of absent pair
      send_request(make_request(OP_INSERT, 0,  0,  0));
      send_request(make_request(OP_INSERT, 31, 31, 63));
      send_request(make_request(OP_INSERT, 31, 0,  0));
      send_request(make_request(OP_INSERT, 0,  31, 0));
      send_request(make_request(OP_INSERT, 31, 31, 0));  // insert of present pair
      send_request(make_request(OP_LOOKUP, 0,  31, 0));  // hit at the last slot
      send_request(make_request(OP_READ,   0,  0,  1));
      send_request(make_request(OP_READ,   0,  0,  63)); // far out of range
      send_request(make_request(OP_READ,   0,  0,  4));  // index equal to count
      send_request(make_request(OP_REMOVE, 0,  0,  0));  // last entry moves to 0
      send_request(make_request(OP_READ,   31, 31, 0));
      send_request(make_request(OP_REMOVE, 31, 31, 0));
      send_request(make_request(OP_REMOVE, 31, 31, 0));  // now absent
      send_request(make_request(OP_LOOKUP, 31, 0,  0));
      send_request(make_request(OP_REMOVE, 0,  31, 0));
      send_request(make_request(OP_REMOVE, 31, 0,  0));  // back to empty
      send_request(make_request(OP_INSERT, 21, 10, 0));
      send_request(make_request(OP_INSERT, 10, 21, 0));
      send_request(make_request(OP_READ,   0,  0,  42));
      send_request(make_request(OP_READ,   0,  0,  21));
      send_request(make_request(OP_LOOKUP, 10, 21, 0));

      // Back up the response side for a long stretch right away.
      pressure_pending = 1'b1;

      growing    = 1'b1;
      full_tries = 0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         // Swap the idle rates at one third, stop idling at two thirds.
         if (k == RANDOM_ITEMS / 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 28;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (growing && sb.stored_count == CAP) full_tries++;
         if (growing && full_tries >= 8) begin
            growing    = 1'b0;
            full_tries = 0;
         end else if (!growing && sb.stored_count == 0) begin
            growing = 1'b1;
         end
         send_request(random_request(growing));
      end
      req_valid <= 1'b0;

      // Drain: wait for every predicted answer, then watch for strays.
      waited = 0;
      while (sb.pending_answers.size() > 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending_answers.size() > 0) begin
         $error("%0d response transactions never arrived", sb.pending_answers.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
